[sv/hfcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfcc_pkg
// Shared codes for the half-float convert and compare unit: operation modes
// and comparison order codes.
// ----------------------------------------------------------------------------
package hfcc_pkg;

    // operation selected per request
    typedef enum logic [1:0] {
        MODE_NARROW  = 2'd0,  // binary32 -> binary16, truncating
        MODE_WIDEN   = 2'd1,  // binary16 -> binary32
        MODE_COMPARE = 2'd2,  // order two halves
        MODE_NONE    = 2'd3   // no operation, flags only
    } mode_t;

    // comparison result
    typedef enum logic [1:0] {
        ORDER_LESS      = 2'd0,
        ORDER_EQUAL     = 2'd1,
        ORDER_GREATER   = 2'd2,
        ORDER_UNORDERED = 2'd3
    } order_t;

    // binary16 field constants
    localparam logic [4:0] HALF_EXP_MAX = 5'h1f;

endpackage

[sv/half_float_convert_compare_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_float_convert_compare_unit
// Half-precision convert / compare unit with stream interfaces.
// ----------------------------------------------------------------------------
// Accepts one request per clock and returns one result per request, in order.
// A request is captured in an input register; the conversion, comparison and
// classification logic sits between that register and the result register,
// so a result appears on m_tvalid once it has moved into the result register.
// Throughput is one request per cycle whenever m_tready is high; when the
// result register is held, the input register still takes one more request.
// Mode (s_tuser): 0 binary32 to binary16 truncating, 1 binary16 to binary32,
// 2 compare two halves, 3 flags only.
// ----------------------------------------------------------------------------
module half_float_convert_compare_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // operand_a[31:0], operand_b[47:32]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // result_bits[31:0], order[33:32],
                                   // is_infinite[34], is_nan[35],
                                   // is_subnormal[36], is_zero[37],
                                   // is_negative[38], magnitude_bits[53:39],
                                   // zero pad[55:54]
);

    // pipeline control
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              out_advance;
    logic              in_load;

    // input stage
    hfcc_pkg::mode_t   mode_reg;
    logic [31:0]       opa_reg;
    logic [15:0]       opb_reg;

    // compute
    logic [15:0]       narrow_half;
    logic [31:0]       widen_single;
    hfcc_pkg::order_t  cmp_order;
    logic [31:0]       result_next;
    hfcc_pkg::order_t  order_next;
    logic [15:0]       class_half;

    // result stage
    logic [31:0]       result_reg;
    hfcc_pkg::order_t  order_reg;
    logic              inf_reg;
    logic              nan_reg;
    logic              sub_reg;
    logic              zero_reg;
    logic              neg_reg;
    logic [14:0]       mag_reg;

    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready    = !in_valid_reg || out_advance;
    assign in_load     = s_tvalid && s_tready;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (in_load) begin
            mode_reg <= hfcc_pkg::mode_t'(s_tuser);
            opa_reg  <= s_tdata[31:0];
            opb_reg  <= s_tdata[47:32];
        end
    end

    hfcc_narrow u_narrow (
        .single_bits (opa_reg),
        .half_bits   (narrow_half)
    );

    hfcc_widen u_widen (
        .half_bits   (opa_reg[15:0]),
        .single_bits (widen_single)
    );

    hfcc_order u_order (
        .lhs   (opa_reg[15:0]),
        .rhs   (opb_reg),
        .order (cmp_order)
    );

    // mode select
    always_comb begin
        unique case (mode_reg)
            hfcc_pkg::MODE_NARROW: begin
                result_next = {16'd0, narrow_half};
                order_next  = hfcc_pkg::ORDER_LESS;
                class_half  = narrow_half;
            end
            hfcc_pkg::MODE_WIDEN: begin
                result_next = widen_single;
                order_next  = hfcc_pkg::ORDER_LESS;
                class_half  = opa_reg[15:0];
            end
            hfcc_pkg::MODE_COMPARE: begin
                result_next = 32'd0;
                order_next  = cmp_order;
                class_half  = opa_reg[15:0];
            end
            default: begin
                result_next = 32'd0;
                order_next  = hfcc_pkg::ORDER_LESS;
                class_half  = opa_reg[15:0];
            end
        endcase
    end

    // result register with classification
    always_ff @(posedge aclk) begin
        if (out_advance && in_valid_reg) begin
            result_reg <= result_next;
            order_reg  <= order_next;
            inf_reg    <= (class_half[14:10] == hfcc_pkg::HALF_EXP_MAX)
                          && (class_half[9:0] == 10'd0);
            nan_reg    <= (class_half[14:10] == hfcc_pkg::HALF_EXP_MAX)
                          && (class_half[9:0] != 10'd0);
            sub_reg    <= (class_half[14:10] == 5'd0) && (class_half[9:0] != 10'd0);
            zero_reg   <= (class_half[14:0] == 15'd0);
            neg_reg    <= class_half[15];
            mag_reg    <= class_half[14:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, mag_reg, neg_reg, zero_reg, sub_reg, nan_reg, inf_reg,
                       order_reg, result_reg};

    // checks
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg))
        else $error("request side stalled with a free stage");

    a_order_only_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_advance && mode_reg != hfcc_pkg::MODE_COMPARE)
        |=> (order_reg == hfcc_pkg::ORDER_LESS))
        else $error("order set outside compare mode");

    a_no_result_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_advance && mode_reg == hfcc_pkg::MODE_COMPARE)
        |=> (result_reg == 32'd0))
        else $error("result bits set in compare mode");

    a_narrow_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_advance && mode_reg == hfcc_pkg::MODE_NARROW)
        |=> (result_reg[31:16] == 16'd0 && mag_reg == result_reg[14:0]))
        else $error("narrowed result does not match classified half");

    a_class_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0({inf_reg, nan_reg, sub_reg, zero_reg}))
        else $error("conflicting classification flags");

endmodule

[sv/hfcc_narrow.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfcc_narrow
// Truncating binary32 to binary16 conversion. Overflow goes to infinity,
// NaN keeps its top mantissa bits, tiny values flush to signed zero.
// ----------------------------------------------------------------------------
module hfcc_narrow (
    input  logic [31:0] single_bits,
    output logic [15:0] half_bits
);

    logic        sgn;
    logic [7:0]  exp8;
    logic [22:0] man;
    logic [7:0]  sub_shift;
    logic [7:0]  norm_exp;
    logic [23:0] sub_man;
    logic [9:0]  nan_top;

    assign sgn       = single_bits[31];
    assign exp8      = single_bits[30:23];
    assign man       = single_bits[22:0];
    assign sub_shift = 8'd113 - exp8;
    assign norm_exp  = exp8 - 8'd112;
    assign sub_man   = {1'b1, man} >> sub_shift[3:0];
    assign nan_top   = (man[22:13] == 10'd0) ? 10'd1 : man[22:13];

    // range select on the biased exponent
    always_comb begin
        if (exp8 >= 8'd143) begin
            if (exp8 == 8'hff && man != 23'd0) begin
                half_bits = {sgn, hfcc_pkg::HALF_EXP_MAX, nan_top};
            end else begin
                half_bits = {sgn, hfcc_pkg::HALF_EXP_MAX, 10'd0};
            end
        end else if (exp8 <= 8'd112) begin
            if (exp8 < 8'd102) begin
                half_bits = {sgn, 15'd0};
            end else begin
                half_bits = {sgn, 5'd0, sub_man[22:13]};
            end
        end else begin
            half_bits = {sgn, norm_exp[4:0], man[22:13]};
        end
    end

endmodule

[sv/hfcc_widen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfcc_widen
// Exact binary16 to binary32 conversion. Subnormals are normalized with a
// leading-zero count; NaN low mantissa bits are filled with ones.
// ----------------------------------------------------------------------------
module hfcc_widen (
    input  logic [15:0] half_bits,
    output logic [31:0] single_bits
);

    logic        sgn;
    logic [4:0]  exp5;
    logic [9:0]  man;
    logic [3:0]  lead_pos;
    logic [3:0]  lz;
    logic [3:0]  norm_shift;
    logic [10:0] norm_man;

    assign sgn  = half_bits[15];
    assign exp5 = half_bits[14:10];
    assign man  = half_bits[9:0];

    // position of the leading one of the subnormal mantissa
    always_comb begin
        lead_pos = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                lead_pos = 4'(i);
            end
        end
    end

    assign lz         = 4'd9 - lead_pos;
    assign norm_shift = lz + 4'd1;
    assign norm_man   = {1'b0, man} << norm_shift;

    // assemble the single by class
    always_comb begin
        if (exp5 == 5'd0) begin
            if (man != 10'd0) begin
                single_bits = {sgn, 8'd112 - {4'd0, lz}, norm_man[9:0], 13'd0};
            end else begin
                single_bits = {sgn, 31'd0};
            end
        end else if (exp5 == hfcc_pkg::HALF_EXP_MAX) begin
            if (man != 10'd0) begin
                single_bits = {sgn, 8'hff, man, 13'h1fff};
            end else begin
                single_bits = {sgn, 8'hff, 23'd0};
            end
        end else begin
            single_bits = {sgn, {3'd0, exp5} + 8'd112, man, 13'd0};
        end
    end

endmodule

[sv/hfcc_order.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfcc_order
// Orders two binary16 values: less, equal, greater or unordered (NaN).
// Signed zeros compare equal.
// ----------------------------------------------------------------------------
module hfcc_order (
    input  logic [15:0]      lhs,
    input  logic [15:0]      rhs,
    output hfcc_pkg::order_t order
);

    logic               lhs_neg;
    logic               rhs_neg;
    logic               lhs_inf;
    logic               rhs_inf;
    logic               lhs_nan;
    logic               rhs_nan;
    logic signed [16:0] lhs_val;
    logic signed [16:0] rhs_val;

    assign lhs_neg = lhs[15];
    assign rhs_neg = rhs[15];
    assign lhs_inf = (lhs[14:10] == hfcc_pkg::HALF_EXP_MAX) && (lhs[9:0] == 10'd0);
    assign rhs_inf = (rhs[14:10] == hfcc_pkg::HALF_EXP_MAX) && (rhs[9:0] == 10'd0);
    assign lhs_nan = (lhs[14:10] == hfcc_pkg::HALF_EXP_MAX) && (lhs[9:0] != 10'd0);
    assign rhs_nan = (rhs[14:10] == hfcc_pkg::HALF_EXP_MAX) && (rhs[9:0] != 10'd0);

    // sign-magnitude to two's complement
    assign lhs_val = lhs_neg ? (17'sd0 - $signed({2'b00, lhs[14:0]}))
                             : $signed({2'b00, lhs[14:0]});
    assign rhs_val = rhs_neg ? (17'sd0 - $signed({2'b00, rhs[14:0]}))
                             : $signed({2'b00, rhs[14:0]});

    // special values first, then integer compare
    always_comb begin
        if (lhs_nan || rhs_nan) begin
            order = hfcc_pkg::ORDER_UNORDERED;
        end else if (lhs_inf && !lhs_neg) begin
            order = (rhs_inf && !rhs_neg) ? hfcc_pkg::ORDER_EQUAL : hfcc_pkg::ORDER_GREATER;
        end else if (lhs_inf && lhs_neg) begin
            order = (rhs_inf && rhs_neg) ? hfcc_pkg::ORDER_EQUAL : hfcc_pkg::ORDER_LESS;
        end else if (rhs_inf && rhs_neg) begin
            order = hfcc_pkg::ORDER_GREATER;
        end else if (rhs_inf) begin
            order = hfcc_pkg::ORDER_LESS;
        end else if (lhs_val > rhs_val) begin
            order = hfcc_pkg::ORDER_GREATER;
        end else if (lhs_val < rhs_val) begin
            order = hfcc_pkg::ORDER_LESS;
        end else begin
            order = hfcc_pkg::ORDER_EQUAL;
        end
    end

endmodule

[sim/half_float_convert_compare_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_float_convert_compare_unit_tb
// Self-checking bench for the half-float convert / compare unit. A small
// scoreboard predicts each result from the accepted request (truncating
// narrowing, exact widening, half ordering, classification). Each returned
// result is checked field by field against it. Directed corner values come
// first, then random requests with random stalls on both channels.
// ----------------------------------------------------------------------------
module half_float_convert_compare_unit_tb;

    localparam int RANDOM_ITEMS  = 1700;
    localparam int CALM_ITEMS    = 200;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;

    // expected fields of one result
    typedef struct packed {
        logic [31:0]      result_bits;
        hfcc_pkg::order_t order;
        logic             is_infinite;
        logic             is_nan;
        logic             is_subnormal;
        logic             is_zero;
        logic             is_negative;
        logic [14:0]      magnitude_bits;
    } half_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts results of accepted requests, checks returned ones
    // ------------------------------------------------------------------------
    class half_result_board;
        half_result_t pending_results[$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // binary32 -> binary16, truncating
        function logic [15:0] narrow_to_half(logic [31:0] w);
            logic [15:0] sgn;
            logic [7:0]  ex;
            logic [22:0] man;
            logic [9:0]  top;
            logic [23:0] sub;
            sgn = {w[31], 15'd0};
            ex  = w[30:23];
            man = w[22:0];
            // overflow, infinity, NaN
            if (ex >= 8'd143) begin
                if (ex == 8'hff && man != 23'd0) begin
                    top = man[22:13];
                    if (top == 10'd0)
                        top = 10'd1;
                    return sgn | 16'h7c00 | {6'd0, top};
                end
                return sgn | 16'h7c00;
            end
            // too small: signed zero
            if (ex < 8'd102)
                return sgn;
            // half subnormal range
            if (ex <= 8'd112) begin
                sub = {1'b1, man} >> (8'd113 - ex);
                return sgn | {6'd0, sub[22:13]};
            end
            return sgn | {1'b0, 5'(ex - 8'd112), man[22:13]};
        endfunction

        // binary16 -> binary32, exact
        function logic [31:0] widen_to_single(logic [15:0] h);
            logic [4:0]  e;
            logic [10:0] m;
            logic [7:0]  ex;
            logic [22:0] frac;
            int          k;
            e    = h[14:10];
            m    = {1'b0, h[9:0]};
            ex   = 8'd0;
            frac = 23'd0;
            if (e == 5'd0) begin
                // normalize subnormals
                if (m != 11'd0) begin
                    ex = 8'h70;
                    m  = m << 1;
                    for (k = 0; k < 10 && !m[10]; k++) begin
                        m  = m << 1;
                        ex = ex - 8'd1;
                    end
                    frac = {m[9:0], 13'd0};
                end
            end else if (e == hfcc_pkg::HALF_EXP_MAX) begin
                ex = 8'hff;
                if (m != 11'd0)
                    frac = {m[9:0], 13'h1fff};
            end else begin
                ex   = {3'd0, e} + 8'h70;
                frac = {m[9:0], 13'd0};
            end
            return {h[15], ex, frac};
        endfunction

        function hfcc_pkg::order_t order_of(logic [15:0] a, logic [15:0] b);
            logic a_nan, b_nan, a_inf, b_inf;
            int   va, vb;
            a_nan = (a[14:10] == hfcc_pkg::HALF_EXP_MAX) && (a[9:0] != 10'd0);
            b_nan = (b[14:10] == hfcc_pkg::HALF_EXP_MAX) && (b[9:0] != 10'd0);
            a_inf = (a[14:10] == hfcc_pkg::HALF_EXP_MAX) && (a[9:0] == 10'd0);
            b_inf = (b[14:10] == hfcc_pkg::HALF_EXP_MAX) && (b[9:0] == 10'd0);
            if (a_nan || b_nan)
                return hfcc_pkg::ORDER_UNORDERED;
            if (a_inf && !a[15])
                return (b_inf && !b[15]) ? hfcc_pkg::ORDER_EQUAL : hfcc_pkg::ORDER_GREATER;
            if (a_inf && a[15])
                return (b_inf && b[15]) ? hfcc_pkg::ORDER_EQUAL : hfcc_pkg::ORDER_LESS;
            if (b_inf)
                return b[15] ? hfcc_pkg::ORDER_GREATER : hfcc_pkg::ORDER_LESS;
            // sign-magnitude to signed; both zeros map to 0
            va = int'(a[14:0]);
            vb = int'(b[14:0]);
            if (a[15])
                va = -va;
            if (b[15])
                vb = -vb;
            if (va > vb)
                return hfcc_pkg::ORDER_GREATER;
            if (va < vb)
                return hfcc_pkg::ORDER_LESS;
            return hfcc_pkg::ORDER_EQUAL;
        endfunction

        function half_result_t predict(hfcc_pkg::mode_t mode, logic [31:0] opa,
                                       logic [15:0] opb);
            half_result_t r;
            logic [15:0]  h;
            r.result_bits = 32'd0;
            r.order       = hfcc_pkg::ORDER_LESS;
            h             = opa[15:0];
            case (mode)
                hfcc_pkg::MODE_NARROW: begin
                    h             = narrow_to_half(opa);
                    r.result_bits = {16'd0, h};
                end
                hfcc_pkg::MODE_WIDEN:   r.result_bits = widen_to_single(h);
                hfcc_pkg::MODE_COMPARE: r.order = order_of(h, opb);
                default: ;
            endcase
            // flags of the classified half
            r.is_infinite    = (h[14:10] == hfcc_pkg::HALF_EXP_MAX) && (h[9:0] == 10'd0);
            r.is_nan         = (h[14:10] == hfcc_pkg::HALF_EXP_MAX) && (h[9:0] != 10'd0);
            r.is_subnormal   = (h[14:10] == 5'd0) && (h[9:0] != 10'd0);
            r.is_zero        = (h[14:0] == 15'd0);
            r.is_negative    = h[15];
            r.magnitude_bits = h[14:0];
            return r;
        endfunction

        function void note_request(hfcc_pkg::mode_t mode, logic [31:0] opa,
                                   logic [15:0] opb);
            pending_results.push_back(predict(mode, opa, opb));
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(logic [55:0] d);
            half_result_t want;
            if (pending_results.size() == 0) begin
                $error("result 0x%0h with no request pending", d);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_bits", want.result_bits, d[31:0]);
            compare_field("order", 32'(want.order), 32'(d[33:32]));
            compare_field("is_infinite", 32'(want.is_infinite), 32'(d[34]));
            compare_field("is_nan", 32'(want.is_nan), 32'(d[35]));
            compare_field("is_subnormal", 32'(want.is_subnormal), 32'(d[36]));
            compare_field("is_zero", 32'(want.is_zero), 32'(d[37]));
            compare_field("is_negative", 32'(want.is_negative), 32'(d[38]));
            compare_field("magnitude_bits", 32'(want.magnitude_bits), 32'(d[53:39]));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // operand_a[31:0], operand_b[47:32]
    logic [1:0]  s_tuser;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // result_bits, order, flags, magnitude_bits, pad
    logic        calm;
    int          quiet_cycles;

    half_result_board board = new();

    half_float_convert_compare_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // monitors: note accepted requests, check accepted results
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && s_tvalid && s_tready)
            board.note_request(hfcc_pkg::mode_t'(s_tuser), s_tdata[31:0], s_tdata[47:32]);
        if (aresetn === 1'b1 && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("half_float_convert_compare_unit_tb: done, errors");
            $finish;
        end
    end

    // result side backpressure in short random bursts
    initial begin
        m_tready <= 1'b0;
        repeat (6) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // one request, with an optional idle gap in front
    task automatic send_request(input hfcc_pkg::mode_t mode, input logic [31:0] opa,
                                input logic [15:0] opb);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {opb, opa};
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off requests until every result is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // random half biased toward the class boundaries
    function automatic logic [15:0] pick_half();
        logic [15:0] h;
        h = 16'($urandom);
        case ($urandom_range(0, 7))
            0: h[14:10] = hfcc_pkg::HALF_EXP_MAX;
            1: begin
                h[14:10] = hfcc_pkg::HALF_EXP_MAX;
                h[9:0]   = 10'd0;
            end
            2: h[14:10] = 5'd0;
            3: h[14:0] = 15'd0;
            4: h[9:0] = 10'(1 << $urandom_range(0, 9));
            default: ;
        endcase
        return h;
    endfunction

    // random single with exponents around the half range and the specials
    function automatic logic [31:0] pick_single();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0, 1, 2: w[30:23] = 8'($urandom_range(98, 146));
            3: w[30:23] = 8'hff;
            4: begin
                w[30:23] = 8'hff;
                w[22:13] = 10'd0;
            end
            5: w[30:23] = 8'($urandom_range(0, 5));
            default: ;
        endcase
        return w;
    endfunction

    task automatic random_request();
        hfcc_pkg::mode_t mode;
        logic [31:0]     opa;
        logic [15:0]     opb;
        logic [15:0]     ha;
        int              pick;
        pick = $urandom_range(0, 9);
        opb  = 16'($urandom);
        if (pick <= 2) begin
            mode = hfcc_pkg::MODE_NARROW;
            opa  = pick_single();
        end else begin
            mode = (pick <= 5) ? hfcc_pkg::MODE_WIDEN :
                   (pick <= 8) ? hfcc_pkg::MODE_COMPARE : hfcc_pkg::MODE_NONE;
            ha   = pick_half();
            opa  = {16'($urandom), ha};
            // right-hand side often close to the left one
            case ($urandom_range(0, 5))
                0: opb = ha;
                1: opb = ha ^ 16'h8000;
                2: opb = ha + 16'd1;
                3: opb = ha - 16'd1;
                4: opb = pick_half();
                default: ;
            endcase
        end
        send_request(mode, opa, opb);
    endtask

    // main sequence
    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= hfcc_pkg::MODE_NARROW;
        aresetn  <= 1'b0;
        calm     <= 1'b0;
        quiet_cycles <= 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // narrowing corners: zeros, specials, overflow edge, subnormal edges
        send_request(hfcc_pkg::MODE_NARROW, 32'h0000_0000, 16'h0000);
        send_request(hfcc_pkg::MODE_NARROW, 32'h8000_0000, 16'hffff);
        send_request(hfcc_pkg::MODE_NARROW, 32'h3f80_0000, 16'h0000);
        send_request(hfcc_pkg::MODE_NARROW, 32'hff80_0000, 16'h0000);
        send_request(hfcc_pkg::MODE_NARROW, 32'h7fc0_0000, 16'h0000);
        send_request(hfcc_pkg::MODE_NARROW, 32'h7f80_0001, 16'h0000);
        send_request(hfcc_pkg::MODE_NARROW, 32'h4780_0000, 16'h0000);
        send_request(hfcc_pkg::MODE_NARROW, 32'h477f_ffff, 16'h0000);
        send_request(hfcc_pkg::MODE_NARROW, 32'h3800_0000, 16'h0000);
        send_request(hfcc_pkg::MODE_NARROW, 32'h3300_0000, 16'h0000);
        send_request(hfcc_pkg::MODE_NARROW, 32'hb2ff_ffff, 16'h0000);
        // widening: zero, subnormals, normal, specials; upper bits ignored
        send_request(hfcc_pkg::MODE_WIDEN, 32'h0000_8000, 16'h0000);
        send_request(hfcc_pkg::MODE_WIDEN, 32'hffff_0001, 16'h0000);
        send_request(hfcc_pkg::MODE_WIDEN, 32'h0000_03ff, 16'h0000);
        send_request(hfcc_pkg::MODE_WIDEN, 32'h0000_7bff, 16'h0000);
        send_request(hfcc_pkg::MODE_WIDEN, 32'h0000_fc00, 16'h0000);
        send_request(hfcc_pkg::MODE_WIDEN, 32'h0000_7c01, 16'h0000);
        // ordering: signed zeros, infinities, NaN on each side, signs
        send_request(hfcc_pkg::MODE_COMPARE, 32'h0000_0000, 16'h8000);
        send_request(hfcc_pkg::MODE_COMPARE, 32'h0000_7c00, 16'h7c00);
        send_request(hfcc_pkg::MODE_COMPARE, 32'h0000_fc00, 16'h7c00);
        send_request(hfcc_pkg::MODE_COMPARE, 32'h0000_7e00, 16'h0000);
        send_request(hfcc_pkg::MODE_COMPARE, 32'h0000_0000, 16'hfe00);
        send_request(hfcc_pkg::MODE_COMPARE, 32'hffff_bc00, 16'h3c00);
        send_request(hfcc_pkg::MODE_COMPARE, 32'h0000_0001, 16'hfc00);
        // unused mode reports flags only
        send_request(hfcc_pkg::MODE_NONE, 32'habcd_7c01, 16'h1234);
        wait_for_results();

        // random requests, with a full drain now and then; quiet at the end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm <= 1'b1;
            if (n % 400 == 399)
                wait_for_results();
            random_request();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatch_count == 0 && board.pending_results.size() == 0)
            $display("half_float_convert_compare_unit_tb: done, clean");
        else
            $display("half_float_convert_compare_unit_tb: done, errors");
        $finish;
    end

endmodule
